@@ design/ffha_pkg.sv @@
// ffha_pkg: shared constants, block table entry type and sequencer states
// for the first-fit heap allocator; no dependencies
package ffha_pkg;

    localparam int HEAP_BYTES   = 1024 * 1024;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_BLOCKS   = 64;

    localparam int OFF_W  = 20;
    localparam int SIZE_W = 21;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_BAD_POINTER = 2'd2
    } status_t;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] size;
        logic             free;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        start: '0,
        size:  OFF_W'(HEAP_BYTES - HEADER_BYTES),
        free:  1'b1
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_WR,
        S_SPLIT_WR2,
        S_ALLOC_DONE,
        S_REL,
        S_MRG_RD,
        S_MRG_CHK,
        S_MRG_END,
        S_RESP
    } state_t;

endpackage

@@ design/ffha_if.sv @@
// ffha_req_if and ffha_rsp_if: valid/ready channels of the allocator
// depends on ffha_pkg for field widths
interface ffha_req_if;
    logic                        valid;
    logic                        ready;
    logic                        has_block;
    logic [ffha_pkg::OFF_W-1:0]  block_offset;
    logic [ffha_pkg::SIZE_W-1:0] new_size;

    modport source (output valid, has_block, block_offset, new_size, input ready);
    modport sink   (input valid, has_block, block_offset, new_size, output ready);
endinterface

interface ffha_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic                       has_result;
    logic [ffha_pkg::OFF_W-1:0] result_offset;

    modport source (output valid, status, has_result, result_offset, input ready);
    modport sink   (input valid, status, has_result, result_offset, output ready);
endinterface

@@ design/ffha_ram.sv @@
// ffha_ram: single write port, single registered read port memory
// generic; no package dependency
module ffha_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/first_fit_heap_allocator_core.sv @@
// first-fit heap allocator: one request per table walk, input ready only while idle
// steps: a lookup pass for the given block, a fit search, a move of each later entry
// when a split opens a slot, and a merge pass when a block is released; all of them
// run one after another on the single table memory
// reset: one free block covering the heap, no clearing pass; result slot empty
// depends on ffha_pkg, ffha_if (ffha_req_if, ffha_rsp_if) and ffha_ram
module first_fit_heap_allocator_core (
    input  logic       clk,
    input  logic       rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);

    localparam logic [21:0] HDR22 = 22'(ffha_pkg::HEADER_BYTES);
    localparam logic [ffha_pkg::OFF_W-1:0] HDR20 = ffha_pkg::OFF_W'(ffha_pkg::HEADER_BYTES);
    localparam logic [ffha_pkg::CNT_W-1:0] MAXC = ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS);

    ffha_pkg::state_t state_reg, state_next;

    logic [ffha_pkg::CNT_W-1:0]  i_reg, i_next;
    logic [ffha_pkg::CNT_W-1:0]  j_reg, j_next;
    logic [ffha_pkg::CNT_W-1:0]  w_reg, w_next;
    logic [ffha_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ffha_pkg::IDX_W-1:0]  old_reg, old_next;
    logic [ffha_pkg::IDX_W-1:0]  fi_reg, fi_next;
    ffha_pkg::entry_t            fit_reg, fit_next;
    ffha_pkg::entry_t            hold_reg, hold_next;
    logic                        hv_reg, hv_next;
    logic                        hb_reg, hb_next;
    logic [ffha_pkg::OFF_W-1:0]  off_reg, off_next;
    logic [ffha_pkg::SIZE_W-1:0] sz_reg, sz_next;
    ffha_pkg::status_t           status_reg, status_next;
    logic                        hres_reg, hres_next;
    logic [ffha_pkg::OFF_W-1:0]  roff_reg, roff_next;
    logic                        e0_wr_reg, e0_wr_next;
    logic                        rd_zero_reg, rd_zero_next;
    logic                        ov_reg, ov_next;
    logic [1:0]                  ost_reg, ost_next;
    logic                        ohr_reg, ohr_next;
    logic [ffha_pkg::OFF_W-1:0]  ooff_reg, ooff_next;

    logic                        ram_we, ram_re;
    logic [ffha_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
    ffha_pkg::entry_t            ram_wdata;
    logic [$bits(ffha_pkg::entry_t)-1:0] ram_rdata;

    ffha_pkg::entry_t            e, mrg_e;
    logic                        find_hit, fits, need_split, i_end, full, merge, in_acc;

    ffha_ram #(
        .WIDTH($bits(ffha_pkg::entry_t)),
        .DEPTH(ffha_pkg::MAX_BLOCKS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // entry read back, entry 0 holds its reset value until first written
    assign e = (rd_zero_reg && !e0_wr_reg) ? ffha_pkg::RESET_ENTRY
                                           : ffha_pkg::entry_t'(ram_rdata);

    // shared compares on the entry just read
    assign find_hit   = !e.free && ((e.start + HDR20) == off_reg);
    assign fits       = e.free && ({2'b00, e.size} >= {1'b0, sz_reg});
    assign need_split = {2'b00, e.size} > ({1'b0, sz_reg} + HDR22);
    assign i_end      = (i_reg == count_reg);
    assign full       = (count_reg >= MAXC);

    always_comb
    begin
        mrg_e = e;
        if (i_reg[ffha_pkg::IDX_W-1:0] == old_reg)
        begin
            mrg_e.free = 1'b1;
        end
    end
    assign merge = hv_reg && hold_reg.free && mrg_e.free;

    assign req.ready     = (state_reg == ffha_pkg::S_IDLE);
    assign in_acc        = req.valid && req.ready;
    assign rsp.valid     = ov_reg;
    assign rsp.status    = ost_reg;
    assign rsp.has_result = ohr_reg;
    assign rsp.result_offset = ooff_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (req.has_block)
                        state_next = ffha_pkg::S_FIND_RD;
                    else if (req.new_size != '0)
                        state_next = ffha_pkg::S_ALLOC_RD;
                    else
                        state_next = ffha_pkg::S_RESP;
                end
            end
            ffha_pkg::S_FIND_RD:
                state_next = i_end ? ffha_pkg::S_RESP : ffha_pkg::S_FIND_CHK;
            ffha_pkg::S_FIND_CHK:
            begin
                if (!find_hit)
                    state_next = ffha_pkg::S_FIND_RD;
                else if (sz_reg != '0)
                    state_next = ffha_pkg::S_ALLOC_RD;
                else
                    state_next = ffha_pkg::S_REL;
            end
            ffha_pkg::S_ALLOC_RD:
                state_next = i_end ? ffha_pkg::S_RESP : ffha_pkg::S_ALLOC_CHK;
            ffha_pkg::S_ALLOC_CHK:
            begin
                if (!fits)
                    state_next = ffha_pkg::S_ALLOC_RD;
                else if (!need_split)
                    state_next = ffha_pkg::S_ALLOC_DONE;
                else if (full)
                    state_next = ffha_pkg::S_RESP;
                else
                    state_next = ffha_pkg::S_SHIFT_RD;
            end
            ffha_pkg::S_SHIFT_RD:
                state_next = (j_reg == ({1'b0, fi_reg} + 1'b1)) ? ffha_pkg::S_SPLIT_WR
                                                                : ffha_pkg::S_SHIFT_WR;
            ffha_pkg::S_SHIFT_WR:   state_next = ffha_pkg::S_SHIFT_RD;
            ffha_pkg::S_SPLIT_WR:   state_next = ffha_pkg::S_SPLIT_WR2;
            ffha_pkg::S_SPLIT_WR2:  state_next = ffha_pkg::S_ALLOC_DONE;
            ffha_pkg::S_ALLOC_DONE:
                state_next = hb_reg ? ffha_pkg::S_REL : ffha_pkg::S_RESP;
            ffha_pkg::S_REL:        state_next = ffha_pkg::S_MRG_RD;
            ffha_pkg::S_MRG_RD:
                state_next = i_end ? ffha_pkg::S_MRG_END : ffha_pkg::S_MRG_CHK;
            ffha_pkg::S_MRG_CHK:    state_next = ffha_pkg::S_MRG_RD;
            ffha_pkg::S_MRG_END:    state_next = ffha_pkg::S_RESP;
            ffha_pkg::S_RESP:
                if (!ov_reg || rsp.ready)
                    state_next = ffha_pkg::S_IDLE;
            default:                state_next = ffha_pkg::S_IDLE;
        endcase
    end

    // datapath, table port and result slot
    always_comb
    begin
        i_next      = i_reg;
        j_next      = j_reg;
        w_next      = w_reg;
        count_next  = count_reg;
        old_next    = old_reg;
        fi_next     = fi_reg;
        fit_next    = fit_reg;
        hold_next   = hold_reg;
        hv_next     = hv_reg;
        hb_next     = hb_reg;
        off_next    = off_reg;
        sz_next     = sz_reg;
        status_next = status_reg;
        hres_next   = hres_reg;
        roff_next   = roff_reg;
        ov_next     = ov_reg;
        ost_next    = ost_reg;
        ohr_next    = ohr_reg;
        ooff_next   = ooff_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = e;
        ram_re      = 1'b0;
        ram_raddr   = i_reg[ffha_pkg::IDX_W-1:0];

        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    hb_next     = req.has_block;
                    off_next    = req.block_offset;
                    sz_next     = req.new_size;
                    status_next = ffha_pkg::ST_OK;
                    hres_next   = 1'b0;
                    roff_next   = '0;
                    i_next      = '0;
                end
            end
            ffha_pkg::S_FIND_RD:
            begin
                if (i_end)
                    status_next = ffha_pkg::ST_BAD_POINTER;
                else
                    ram_re = 1'b1;
            end
            ffha_pkg::S_FIND_CHK:
            begin
                if (find_hit)
                begin
                    old_next = i_reg[ffha_pkg::IDX_W-1:0];
                    i_next   = '0;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            ffha_pkg::S_ALLOC_RD:
            begin
                if (i_end)
                    status_next = ffha_pkg::ST_NO_SPACE;
                else
                    ram_re = 1'b1;
            end
            ffha_pkg::S_ALLOC_CHK:
            begin
                if (fits)
                begin
                    fit_next  = e;
                    fi_next   = i_reg[ffha_pkg::IDX_W-1:0];
                    roff_next = e.start + HDR20;
                    j_next    = count_reg;
                    if (!need_split)
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = i_reg[ffha_pkg::IDX_W-1:0];
                        ram_wdata      = e;
                        ram_wdata.free = 1'b0;
                    end
                    else if (full)
                        status_next = ffha_pkg::ST_NO_SPACE;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            ffha_pkg::S_SHIFT_RD:
            begin
                ram_raddr = ffha_pkg::IDX_W'(j_reg - 1'b1);
                if (j_reg != ({1'b0, fi_reg} + 1'b1))
                    ram_re = 1'b1;
            end
            ffha_pkg::S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[ffha_pkg::IDX_W-1:0];
                ram_wdata = e;
                j_next    = j_reg - 1'b1;
            end
            ffha_pkg::S_SPLIT_WR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = fi_reg + 1'b1;
                ram_wdata.start = fit_reg.start + HDR20 + sz_reg[ffha_pkg::OFF_W-1:0];
                ram_wdata.size  = fit_reg.size - sz_reg[ffha_pkg::OFF_W-1:0] - HDR20;
                ram_wdata.free  = 1'b1;
            end
            ffha_pkg::S_SPLIT_WR2:
            begin
                ram_we          = 1'b1;
                ram_waddr       = fi_reg;
                ram_wdata.start = fit_reg.start;
                ram_wdata.size  = sz_reg[ffha_pkg::OFF_W-1:0];
                ram_wdata.free  = 1'b0;
                count_next      = count_reg + 1'b1;
                // the old block moves up one slot when it sits after the split
                if (old_reg > fi_reg)
                    old_next = old_reg + 1'b1;
            end
            ffha_pkg::S_ALLOC_DONE:
                hres_next = 1'b1;
            ffha_pkg::S_REL:
            begin
                i_next  = '0;
                w_next  = '0;
                hv_next = 1'b0;
            end
            ffha_pkg::S_MRG_RD:
            begin
                if (!i_end)
                    ram_re = 1'b1;
            end
            ffha_pkg::S_MRG_CHK:
            begin
                // fold a free run into the held entry, else flush it
                if (merge)
                    hold_next.size = hold_reg.size + mrg_e.size + HDR20;
                else
                begin
                    if (hv_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ffha_pkg::IDX_W'(w_reg - 1'b1);
                        ram_wdata = hold_reg;
                    end
                    hold_next = mrg_e;
                    hv_next   = 1'b1;
                    w_next    = w_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            ffha_pkg::S_MRG_END:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ffha_pkg::IDX_W'(w_reg - 1'b1);
                ram_wdata  = hold_reg;
                count_next = w_reg;
            end
            ffha_pkg::S_RESP:
            begin
                // offset is null unless a block was handed out
                if (!ov_reg || rsp.ready)
                begin
                    ov_next   = 1'b1;
                    ost_next  = status_reg;
                    ohr_next  = hres_reg;
                    ooff_next = hres_reg ? roff_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign e0_wr_next   = e0_wr_reg || (ram_we && (ram_waddr == '0));
    assign rd_zero_next = ram_re ? (ram_raddr == '0) : rd_zero_reg;

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ffha_pkg::S_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            w_reg       <= '0;
            count_reg   <= ffha_pkg::CNT_W'(1);
            old_reg     <= '0;
            fi_reg      <= '0;
            fit_reg     <= '0;
            hold_reg    <= '0;
            hv_reg      <= 1'b0;
            hb_reg      <= 1'b0;
            off_reg     <= '0;
            sz_reg      <= '0;
            status_reg  <= ffha_pkg::ST_OK;
            hres_reg    <= 1'b0;
            roff_reg    <= '0;
            e0_wr_reg   <= 1'b0;
            rd_zero_reg <= 1'b0;
            ov_reg      <= 1'b0;
            ost_reg     <= '0;
            ohr_reg     <= 1'b0;
            ooff_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            w_reg       <= w_next;
            count_reg   <= count_next;
            old_reg     <= old_next;
            fi_reg      <= fi_next;
            fit_reg     <= fit_next;
            hold_reg    <= hold_next;
            hv_reg      <= hv_next;
            hb_reg      <= hb_next;
            off_reg     <= off_next;
            sz_reg      <= sz_next;
            status_reg  <= status_next;
            hres_reg    <= hres_next;
            roff_reg    <= roff_next;
            e0_wr_reg   <= e0_wr_next;
            rd_zero_reg <= rd_zero_next;
            ov_reg      <= ov_next;
            ost_reg     <= ost_next;
            ohr_reg     <= ohr_next;
            ooff_reg    <= ooff_next;
        end
    end

`ifndef SYNTHESIS
    // the table always holds between one and the maximum number of blocks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= MAXC))
        else $error("block count out of range");

    // the table is never written while waiting for a request
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffha_pkg::S_IDLE) |-> !ram_we)
        else $error("table written while idle");

    // an accepted request always starts a walk or goes to the result slot
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != ffha_pkg::S_IDLE))
        else $error("request accepted but sequencer stayed idle");
`endif

endmodule
